// ----- hdl/bblru_pkg.sv -----
// Shared types and constants for the byte-budget LRU cache tracker.
package bblru_pkg;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCAN,
    ST_CHECK,
    ST_EVSCAN,
    ST_BUMP,
    ST_FILL,
    ST_PROMO,
    ST_RESP
  } state_t;

  typedef enum logic [1:0] {
    ACT_ACCESS = 2'd0,
    ACT_TOUCH  = 2'd1,
    ACT_PROBE  = 2'd2,
    ACT_CLEAR  = 2'd3
  } action_t;

  localparam int ACT_W  = 2;
  localparam int KEY_W  = 32;
  localparam int SIZE_W = 32;
  localparam int PAGE_W = 32;
  localparam int SLOT_W = 6;
  localparam int EVN_W  = 7;
  localparam int USED_W = 25;
  localparam int CNT_W  = 32;
  localparam int CAP_W  = 25;
  localparam int CFG_AW = 3;
  localparam int CFG_DW = 32;

  // Register index as carried by the word-address bit of paddr.
  localparam logic REG_CAPACITY = 1'b0;

endpackage

// ----- hdl/bblru_if.sv -----
// Valid/ready channel interfaces for request and result beats.
interface bblru_req_if;
  import bblru_pkg::*;
  logic              valid;
  logic              ready;
  logic [ACT_W-1:0]  action;
  logic [KEY_W-1:0]  item_key;
  logic [SIZE_W-1:0] item_bytes;
  modport source(output valid, action, item_key, item_bytes, input ready);
  modport sink(input valid, action, item_key, item_bytes, output ready);
endinterface

interface bblru_rsp_if;
  import bblru_pkg::*;
  logic              valid;
  logic              ready;
  logic              hit;
  logic [SLOT_W-1:0] slot;
  logic              slot_valid;
  logic [EVN_W-1:0]  evicted_now;
  logic [USED_W-1:0] used_pages;
  logic [CNT_W-1:0]  hit_total;
  logic [CNT_W-1:0]  miss_total;
  logic [CNT_W-1:0]  evict_total;
  modport source(output valid, hit, slot, slot_valid, evicted_now, used_pages, hit_total,
                 miss_total, evict_total, input ready);
  modport sink(input valid, hit, slot, slot_valid, evicted_now, used_pages, hit_total,
               miss_total, evict_total, output ready);
endinterface

// ----- hdl/byte_budget_lru_cache.sv -----
// Top level: size-aware LRU cache tracker with a page budget.
//
//  channel  | dir | handshake            | beat content
//  ---------+-----+----------------------+-------------------------------------------
//  in_if    | in  | valid/ready          | action, item_key, item_bytes
//  out_if   | out | valid/ready          | hit, slot, slot_valid, evicted_now, used_pages,
//           |     |                      | hit_total, miss_total, evict_total
//  APB      | in  | psel/penable, pready | capacity_pages at byte address 0
//
// One request at a time. Every slot sweep reads the entry memory one slot per
// cycle. Probe: one sweep. Hit of access or touch: two sweeps. Touch miss: one
// sweep. Access miss: one sweep and a check state, then one sweep and one more
// check state per eviction, one rank sweep and a fill state. The page round-up is
// a shift and a mask taken at accept, so PAGE_BYTES must be a power of two.
// Clear statistics goes from accept straight to the result.
// Reset clears valid bits, counters and the budget; no clearing pass is needed.
// A result waiting on out_if.ready holds the block; in_if.ready is low until taken.
module byte_budget_lru_cache #(
  parameter int MAX_ENTRIES = 64,
  parameter int PAGE_BYTES  = 4096
) (
  input  logic                         clk,
  input  logic                         rst_n,
  bblru_req_if.sink                    in_if,
  bblru_rsp_if.source                  out_if,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [bblru_pkg::CFG_AW-1:0] paddr,
  input  logic [bblru_pkg::CFG_DW-1:0] pwdata,
  output logic [bblru_pkg::CFG_DW-1:0] prdata,
  output logic                         pready
);
  import bblru_pkg::*;

  localparam int IDX_W = $clog2(MAX_ENTRIES);
  localparam int LIV_W = $clog2(MAX_ENTRIES + 1);
  localparam int UW    = PAGE_W + IDX_W + 1;   // exact page total
  localparam int EW    = KEY_W + PAGE_W + IDX_W;
  localparam int PG_SH = $clog2(PAGE_BYTES);
  localparam logic [SIZE_W-1:0] PG_MASK  = SIZE_W'(PAGE_BYTES - 1);
  localparam logic [IDX_W-1:0]  LAST_IDX = IDX_W'(MAX_ENTRIES - 1);
  localparam logic [LIV_W-1:0]  FULL     = LIV_W'(MAX_ENTRIES);
  localparam logic [UW-1:0]     USED_SAT = UW'({USED_W{1'b1}});

  // Entry memory: key, pages, recency rank (0 = most recent).
  logic [EW-1:0] mem [MAX_ENTRIES];
  logic [EW-1:0] mem_q_r;
  logic          mem_re, mem_we;
  logic [IDX_W-1:0] mem_ra, mem_wa;
  logic [EW-1:0] mem_wd;

  state_t state_r, state_nxt;

  logic [ACT_W-1:0]  act_r, act_nxt;
  logic [KEY_W-1:0]  key_r, key_nxt;
  logic [PAGE_W-1:0] need_r, need_nxt;
  logic [UW-1:0]     used_r, used_nxt;
  logic [LIV_W-1:0]  live_r, live_nxt;
  logic [MAX_ENTRIES-1:0] vld_r, vld_nxt;
  logic [CNT_W-1:0]  hcnt_r, hcnt_nxt, mcnt_r, mcnt_nxt, ecnt_r, ecnt_nxt;
  logic              found_r, found_nxt;
  logic [IDX_W-1:0]  fslot_r, fslot_nxt;
  logic [IDX_W-1:0]  frank_r, frank_nxt;
  logic [IDX_W-1:0]  vslot_r, vslot_nxt;
  logic [PAGE_W-1:0] vpages_r, vpages_nxt;
  logic              fseen_r, fseen_nxt;
  logic [IDX_W-1:0]  free_r, free_nxt;
  logic [LIV_W-1:0]  evn_r, evn_nxt;
  logic              rhit_r, rhit_nxt, rsv_r, rsv_nxt;
  logic [IDX_W-1:0]  rslot_r, rslot_nxt;
  logic [IDX_W-1:0]  rd_idx_r, rd_idx_nxt, p_idx_r, p_idx_nxt;
  logic              iss_r, iss_nxt, p_vld_r, p_vld_nxt;
  logic [CAP_W-1:0]  cap_r;

  // Read stage view of the slot delivered this cycle.
  logic [KEY_W-1:0]  q_key;
  logic [PAGE_W-1:0] q_pages;
  logic [IDX_W-1:0]  q_rank;
  logic              q_live, sweep_done, sweep_start, in_acc;
  logic [UW:0]       want;
  logic              over_budget;

  assign q_key      = mem_q_r[EW-1 -: KEY_W];
  assign q_pages    = mem_q_r[IDX_W +: PAGE_W];
  assign q_rank     = mem_q_r[IDX_W-1:0];
  assign q_live     = vld_r[p_idx_r];
  assign sweep_done = p_vld_r && (p_idx_r == LAST_IDX);
  assign in_acc     = in_if.valid && in_if.ready;

  // Does the pending item overflow the budget?
  assign want        = (UW + 1)'(used_r) + (UW + 1)'(need_r);
  assign over_budget = (want > (UW + 1)'(cap_r)) && (live_r != '0);

  // ---------------------------------------------------------------- next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_if.valid) begin
          state_nxt = (in_if.action == ACT_CLEAR) ? ST_RESP : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (sweep_done) begin
          if (found_r || (q_live && q_key == key_r)) begin
            state_nxt = (act_r == ACT_PROBE) ? ST_RESP : ST_PROMO;
          end else begin
            state_nxt = (act_r == ACT_ACCESS) ? ST_CHECK : ST_RESP;
          end
        end
      end
      ST_CHECK: begin
        state_nxt = (over_budget || live_r == FULL) ? ST_EVSCAN : ST_BUMP;
      end
      ST_EVSCAN: begin
        if (sweep_done) state_nxt = ST_CHECK;
      end
      ST_BUMP: begin
        if (sweep_done) state_nxt = ST_FILL;
      end
      ST_FILL:  state_nxt = ST_RESP;
      ST_PROMO: begin
        if (sweep_done) state_nxt = ST_RESP;
      end
      ST_RESP: begin
        if (out_if.ready) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign sweep_start = (state_nxt != state_r) &&
                       (state_nxt == ST_SCAN || state_nxt == ST_PROMO ||
                        state_nxt == ST_EVSCAN || state_nxt == ST_BUMP);

  // ---------------------------------------------------------------- datapath
  always_comb begin
    act_nxt    = act_r;
    key_nxt    = key_r;
    need_nxt   = need_r;
    used_nxt   = used_r;
    live_nxt   = live_r;
    vld_nxt    = vld_r;
    hcnt_nxt   = hcnt_r;
    mcnt_nxt   = mcnt_r;
    ecnt_nxt   = ecnt_r;
    found_nxt  = found_r;
    fslot_nxt  = fslot_r;
    frank_nxt  = frank_r;
    vslot_nxt  = vslot_r;
    vpages_nxt = vpages_r;
    fseen_nxt  = fseen_r;
    free_nxt   = free_r;
    evn_nxt    = evn_r;
    rhit_nxt   = rhit_r;
    rsv_nxt    = rsv_r;
    rslot_nxt  = rslot_r;
    mem_re     = 1'b0;
    mem_ra     = rd_idx_r;
    mem_we     = 1'b0;
    mem_wa     = p_idx_r;
    mem_wd     = mem_q_r;

    // Sweep read issue: one slot per cycle, data lands in the cycle after issue.
    rd_idx_nxt = rd_idx_r;
    iss_nxt    = iss_r;
    p_vld_nxt  = 1'b0;
    p_idx_nxt  = rd_idx_r;
    if (iss_r) begin
      mem_re     = 1'b1;
      p_vld_nxt  = 1'b1;
      if (rd_idx_r == LAST_IDX) begin
        iss_nxt = 1'b0;
      end else begin
        rd_idx_nxt = rd_idx_r + 1'b1;
      end
    end
    if (sweep_start) begin
      rd_idx_nxt = '0;
      iss_nxt    = 1'b1;
      fseen_nxt  = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          act_nxt   = in_if.action;
          key_nxt   = in_if.item_key;
          // Round the byte size up to whole pages.
          need_nxt  = PAGE_W'(in_if.item_bytes >> PG_SH) +
                      PAGE_W'((in_if.item_bytes & PG_MASK) != '0);
          found_nxt = 1'b0;
          evn_nxt   = '0;
          rhit_nxt  = 1'b0;
          rsv_nxt   = 1'b0;
          rslot_nxt = '0;
          if (in_if.action == ACT_CLEAR) begin
            hcnt_nxt = '0;
            mcnt_nxt = '0;
            ecnt_nxt = '0;
          end
        end
      end
      ST_SCAN: begin
        // Keep the first live slot whose key matches.
        if (p_vld_r && q_live && q_key == key_r && !found_r) begin
          found_nxt = 1'b1;
          fslot_nxt = p_idx_r;
          frank_nxt = q_rank;
        end
        if (sweep_done) begin
          if (found_nxt) begin
            rhit_nxt  = 1'b1;
            rsv_nxt   = 1'b1;
            rslot_nxt = fslot_nxt;
            if (act_r == ACT_ACCESS) hcnt_nxt = hcnt_r + 1'b1;
          end else if (act_r == ACT_ACCESS) begin
            mcnt_nxt = mcnt_r + 1'b1;
          end
        end
      end
      ST_EVSCAN: begin
        // Victim is the live slot holding the oldest rank.
        if (p_vld_r && q_live && q_rank == IDX_W'(live_r - 1'b1)) begin
          vslot_nxt  = p_idx_r;
          vpages_nxt = q_pages;
        end
        if (sweep_done) begin
          vld_nxt[vslot_nxt] = 1'b0;
          used_nxt = used_r - UW'(vpages_nxt);
          live_nxt = live_r - 1'b1;
          evn_nxt  = evn_r + 1'b1;
          ecnt_nxt = ecnt_r + 1'b1;
        end
      end
      ST_BUMP: begin
        // Age every live entry; note the lowest free slot on the way.
        if (p_vld_r) begin
          if (q_live) begin
            mem_we = 1'b1;
            mem_wd = {q_key, q_pages, q_rank + 1'b1};
          end else if (!fseen_r) begin
            fseen_nxt = 1'b1;
            free_nxt  = p_idx_r;
          end
        end
      end
      ST_FILL: begin
        mem_we          = 1'b1;
        mem_wa          = free_r;
        mem_wd          = {key_r, need_r, IDX_W'(0)};
        vld_nxt[free_r] = 1'b1;
        used_nxt        = used_r + UW'(need_r);
        live_nxt        = live_r + 1'b1;
        rsv_nxt         = 1'b1;
        rslot_nxt       = free_r;
      end
      ST_PROMO: begin
        // Move the hit to the front; shift the newer ones back by one.
        if (p_vld_r && q_live) begin
          mem_we = 1'b1;
          if (p_idx_r == fslot_r) begin
            mem_wd = {q_key, q_pages, IDX_W'(0)};
          end else if (q_rank < frank_r) begin
            mem_wd = {q_key, q_pages, q_rank + 1'b1};
          end
        end
      end
      default: ;
    endcase
  end

  // ---------------------------------------------------------------- registers
  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    if (mem_re) mem_q_r <= mem[mem_ra];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      vld_r   <= '0;
      used_r  <= '0;
      live_r  <= '0;
      hcnt_r  <= '0;
      mcnt_r  <= '0;
      ecnt_r  <= '0;
      iss_r   <= 1'b0;
      p_vld_r <= 1'b0;
      cap_r   <= '0;
    end else begin
      state_r <= state_nxt;
      vld_r   <= vld_nxt;
      used_r  <= used_nxt;
      live_r  <= live_nxt;
      hcnt_r  <= hcnt_nxt;
      mcnt_r  <= mcnt_nxt;
      ecnt_r  <= ecnt_nxt;
      iss_r   <= iss_nxt;
      p_vld_r <= p_vld_nxt;
      if (psel && penable && pwrite && paddr[CFG_AW-1] == REG_CAPACITY) begin
        cap_r <= pwdata[CAP_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    act_r    <= act_nxt;
    key_r    <= key_nxt;
    need_r   <= need_nxt;
    found_r  <= found_nxt;
    fslot_r  <= fslot_nxt;
    frank_r  <= frank_nxt;
    vslot_r  <= vslot_nxt;
    vpages_r <= vpages_nxt;
    fseen_r  <= fseen_nxt;
    free_r   <= free_nxt;
    evn_r    <= evn_nxt;
    rhit_r   <= rhit_nxt;
    rsv_r    <= rsv_nxt;
    rslot_r  <= rslot_nxt;
    rd_idx_r <= rd_idx_nxt;
    p_idx_r  <= p_idx_nxt;
  end

  // ---------------------------------------------------------------- ports
  assign in_if.ready        = (state_r == ST_IDLE);
  assign out_if.valid       = (state_r == ST_RESP);
  assign out_if.hit         = rhit_r;
  assign out_if.slot        = SLOT_W'(rslot_r);
  assign out_if.slot_valid  = rsv_r;
  assign out_if.evicted_now = (int'(evn_r) > 127) ? 7'd127 : EVN_W'(evn_r);
  assign out_if.used_pages  = (used_r > USED_SAT) ? {USED_W{1'b1}} : used_r[USED_W-1:0];
  assign out_if.hit_total   = hcnt_r;
  assign out_if.miss_total  = mcnt_r;
  assign out_if.evict_total = ecnt_r;

  assign pready = 1'b1;
  assign prdata = (paddr[CFG_AW-1] == REG_CAPACITY) ? CFG_DW'(cap_r) : '0;

endmodule
